### hdl/bezier_response_curve_eval_defines.svh
// assertion macros for the checker file
`ifndef BEZIER_RESPONSE_CURVE_EVAL_DEFINES_SVH
`define BEZIER_RESPONSE_CURVE_EVAL_DEFINES_SVH

// same-cycle implication, sampled on the block clock outside reset
`define BRE_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, sampled on the block clock outside reset
`define BRE_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### hdl/bre_pkg.sv
// shared types, constants and the fixed-point lerp for the bezier curve evaluator
package bre_pkg;

    localparam int COORD_W      = 16;
    localparam int T_W          = 16;
    localparam int MAX_POINTS   = 16;
    localparam int IDX_W        = 4;
    localparam int CNT_W        = 5;
    localparam int TOL_W        = 8;
    localparam int BISECT_STEPS = 16;
    localparam int STEP_W       = 5;

    // action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;

    // configuration register indexes
    localparam logic CFG_POINT_COUNT = 1'b0;
    localparam logic CFG_MATCH_TOL   = 1'b1;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [T_W-1:0]     t_frac;

    // one table entry as stored in the point memory
    typedef struct packed {
        t_coord anchor_x;
        t_coord anchor_y;
        t_coord entry_ctrl_x;
        t_coord entry_ctrl_y;
        t_coord exit_ctrl_x;
        t_coord exit_ctrl_y;
    } t_point;

    // control into the cubic unit
    typedef struct packed {
        logic start;
    } t_cub_ctl;

    // status out of the cubic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_cub_stat;

    // rounded linear interpolation a + (b - a) * t
    function automatic t_coord lerp(t_coord a, t_coord b, t_frac t);
        logic                     up;
        t_coord                   d;
        logic [COORD_W+T_W-1:0]   p;
        logic [COORD_W+T_W:0]     r;
        t_coord                   s;
        up = (b >= a);
        d  = up ? (b - a) : (a - b);
        p  = {{T_W{1'b0}}, d} * {{COORD_W{1'b0}}, t};
        r  = {1'b0, p} + {{(COORD_W + 1){1'b0}}, 1'b1, {(T_W - 1){1'b0}}};
        s  = r[T_W +: COORD_W];
        return up ? (a + s) : (a - s);
    endfunction

endpackage

### hdl/bre_ram.sv
// generic single write port ram with registered read
module bre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/bre_cubic.sv
// three-level de casteljau unit for one coordinate, one level per cycle
module bre_cubic (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bre_pkg::t_cub_ctl i_ctl,
    input  bre_pkg::t_coord   i_p0,
    input  bre_pkg::t_coord   i_p1,
    input  bre_pkg::t_coord   i_p2,
    input  bre_pkg::t_coord   i_p3,
    input  bre_pkg::t_frac    i_t,
    output bre_pkg::t_coord   o_val,
    output bre_pkg::t_cub_stat o_stat
);

    localparam logic [1:0] LVL_FIRST  = 2'd0;
    localparam logic [1:0] LVL_SECOND = 2'd1;
    localparam logic [1:0] LVL_THIRD  = 2'd2;

    logic            r_busy;
    logic            r_done;
    logic [1:0]      r_lvl;
    bre_pkg::t_coord r_a;
    bre_pkg::t_coord r_b;
    bre_pkg::t_coord r_c;
    logic            w_first;
    bre_pkg::t_coord w_la;
    bre_pkg::t_coord w_lb;
    bre_pkg::t_coord w_lc;

    // lane inputs come from the control polygon on the first level
    assign w_first = (r_lvl == LVL_FIRST);
    assign w_la = bre_pkg::lerp(w_first ? i_p0 : r_a, w_first ? i_p1 : r_b, i_t);
    assign w_lb = bre_pkg::lerp(w_first ? i_p1 : r_b, w_first ? i_p2 : r_c, i_t);
    assign w_lc = bre_pkg::lerp(i_p2, i_p3, i_t);

    // level sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_lvl  <= LVL_FIRST;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start && !r_busy) begin
                r_busy <= 1'b1;
                r_lvl  <= LVL_FIRST;
            end else if (r_busy) begin
                if (r_lvl == LVL_THIRD) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_lvl  <= LVL_FIRST;
                end else begin
                    r_lvl <= r_lvl + 2'd1;
                end
            end
        end
    end

    // intermediate points
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_a <= w_la;
            if (r_lvl != LVL_THIRD) begin
                r_b <= w_lb;
            end
            if (r_lvl == LVL_FIRST) begin
                r_c <= w_lc;
            end
        end
    end

    assign o_val       = r_a;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

### hdl/bezier_response_curve_eval.sv
// top level: point table, segment search and bisection sequencer
// Maps query_x to y through a piecewise cubic bezier curve held in a 16-entry point
// memory. A write transfer stores one point. An evaluate transfer reads the first
// and last points, so the edge rules can give a valid result through the FIRST, LAST,
// EDGE and PUSH states. Otherwise it scans the table one entry per cycle from the
// memory's single read port, then runs up to 16 bisection steps and one final
// evaluation, each through a registered start and the three-level de casteljau unit.
// The result sits in an output register, so the next transfer is taken while it waits.
module bezier_response_curve_eval (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [bre_pkg::TOL_W-1:0]  i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_action,
    input  logic [bre_pkg::IDX_W-1:0]  i_point_index,
    input  bre_pkg::t_coord            i_anchor_x,
    input  bre_pkg::t_coord            i_anchor_y,
    input  bre_pkg::t_coord            i_entry_ctrl_x,
    input  bre_pkg::t_coord            i_entry_ctrl_y,
    input  bre_pkg::t_coord            i_exit_ctrl_x,
    input  bre_pkg::t_coord            i_exit_ctrl_y,
    input  bre_pkg::t_coord            i_query_x,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output bre_pkg::t_coord            o_curve_y,
    output logic                       o_converged,
    output logic [bre_pkg::IDX_W-1:0]  o_segment_used
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIRST = 3'd1;
    localparam logic [2:0] S_LAST  = 3'd2;
    localparam logic [2:0] S_EDGE  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_BIS   = 3'd5;
    localparam logic [2:0] S_FINAL = 3'd6;
    localparam logic [2:0] S_PUSH  = 3'd7;

    localparam logic [bre_pkg::T_W:0] T_ONE = {1'b1, {bre_pkg::T_W{1'b0}}};

    logic [2:0]                   r_state, n_state;
    bre_pkg::t_coord              r_q, n_q;
    bre_pkg::t_point              r_prev, n_prev;
    bre_pkg::t_point              r_cur, n_cur;
    logic [bre_pkg::IDX_W-1:0]    r_j, n_j;
    logic [bre_pkg::T_W:0]        r_lo, n_lo;
    logic [bre_pkg::T_W:0]        r_hi, n_hi;
    bre_pkg::t_frac               r_t, n_t;
    logic [bre_pkg::STEP_W-1:0]   r_step, n_step;
    logic                         r_start, n_start;
    bre_pkg::t_coord              r_last_y, n_last_y;
    bre_pkg::t_coord              r_res_y, n_res_y;
    logic                         r_res_conv, n_res_conv;
    logic [bre_pkg::IDX_W-1:0]    r_res_seg, n_res_seg;
    logic                         r_ov, n_ov;
    bre_pkg::t_coord              r_oy, n_oy;
    logic                         r_oc, n_oc;
    logic [bre_pkg::IDX_W-1:0]    r_os, n_os;
    logic [bre_pkg::CNT_W-1:0]    r_pc;
    logic [bre_pkg::TOL_W-1:0]    r_tol;

    logic [bre_pkg::CNT_W-1:0]    w_n;
    logic [bre_pkg::CNT_W-1:0]    w_n_m1;
    logic [bre_pkg::IDX_W-1:0]    w_last;
    logic                         w_acc;
    logic                         w_we;
    bre_pkg::t_point              w_wdata;
    logic [bre_pkg::IDX_W-1:0]    w_raddr;
    bre_pkg::t_point              w_rdata;
    logic [$bits(bre_pkg::t_point)-1:0] w_rraw;
    bre_pkg::t_cub_ctl            w_ctl;
    bre_pkg::t_coord              w_xm;
    bre_pkg::t_coord              w_ym;
    bre_pkg::t_cub_stat           w_xs;
    bre_pkg::t_cub_stat           w_ys;
    bre_pkg::t_coord              w_err;
    logic [bre_pkg::T_W+1:0]      w_sum;

    // points in use, saturated to the table depth
    assign w_n    = (r_pc > bre_pkg::CNT_W'(bre_pkg::MAX_POINTS))
                    ? bre_pkg::CNT_W'(bre_pkg::MAX_POINTS) : r_pc;
    assign w_n_m1 = w_n - bre_pkg::CNT_W'(1);
    assign w_last = w_n_m1[bre_pkg::IDX_W-1:0];

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;

    // point memory write on a write transfer
    assign w_we = w_acc && (i_action == bre_pkg::ACT_WRITE);
    always_comb begin
        w_wdata.anchor_x     = i_anchor_x;
        w_wdata.anchor_y     = i_anchor_y;
        w_wdata.entry_ctrl_x = i_entry_ctrl_x;
        w_wdata.entry_ctrl_y = i_entry_ctrl_y;
        w_wdata.exit_ctrl_x  = i_exit_ctrl_x;
        w_wdata.exit_ctrl_y  = i_exit_ctrl_y;
    end

    // read address per sequencer state
    always_comb begin
        unique case (r_state)
            S_LAST:  w_raddr = w_last;
            S_EDGE:  w_raddr = bre_pkg::IDX_W'(1);
            S_SCAN:  w_raddr = r_j + bre_pkg::IDX_W'(1);
            default: w_raddr = '0;
        endcase
    end

    bre_ram #(
        .WIDTH ($bits(bre_pkg::t_point)),
        .DEPTH (bre_pkg::MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_point_index),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rraw)
    );
    assign w_rdata = w_rraw;

    // cubic units for x and y over segment prev -> cur
    assign w_ctl.start = r_start;

    bre_cubic u_cub_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_p0    (r_prev.anchor_x),
        .i_p1    (r_prev.exit_ctrl_x),
        .i_p2    (r_cur.entry_ctrl_x),
        .i_p3    (r_cur.anchor_x),
        .i_t     (r_t),
        .o_val   (w_xm),
        .o_stat  (w_xs)
    );

    bre_cubic u_cub_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_p0    (r_prev.anchor_y),
        .i_p1    (r_prev.exit_ctrl_y),
        .i_p2    (r_cur.entry_ctrl_y),
        .i_p3    (r_cur.anchor_y),
        .i_t     (r_t),
        .o_val   (w_ym),
        .o_stat  (w_ys)
    );

    assign w_err = (w_xm >= r_q) ? (w_xm - r_q) : (r_q - w_xm);

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_q        = r_q;
        n_prev     = r_prev;
        n_cur      = r_cur;
        n_j        = r_j;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_t        = r_t;
        n_step     = r_step;
        n_start    = 1'b0;
        n_last_y   = r_last_y;
        n_res_y    = r_res_y;
        n_res_conv = r_res_conv;
        n_res_seg  = r_res_seg;
        n_ov       = r_ov && !i_out_ready;
        n_oy       = r_oy;
        n_oc       = r_oc;
        n_os       = r_os;
        w_sum      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && (i_action == bre_pkg::ACT_EVAL)) begin
                    n_q     = i_query_x;
                    n_state = S_FIRST;
                end
            end
            S_FIRST: begin
                n_state = S_LAST;
            end
            S_LAST: begin
                n_prev  = w_rdata;
                n_state = S_EDGE;
            end
            S_EDGE: begin
                n_res_conv = 1'b1;
                n_res_seg  = '0;
                n_last_y   = w_rdata.anchor_y;
                if (w_n == '0) begin
                    n_res_y = '0;
                    n_state = S_PUSH;
                end else if (r_q <= r_prev.anchor_x) begin
                    n_res_y = r_prev.anchor_y;
                    n_state = S_PUSH;
                end else if (r_q >= w_rdata.anchor_x) begin
                    n_res_y = w_rdata.anchor_y;
                    n_state = S_PUSH;
                end else begin
                    n_j     = bre_pkg::IDX_W'(1);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if ((r_q >= r_prev.anchor_x) && (r_q <= w_rdata.anchor_x)) begin
                    n_cur     = w_rdata;
                    n_res_seg = r_j - bre_pkg::IDX_W'(1);
                    n_lo      = '0;
                    n_hi      = T_ONE;
                    n_t       = T_ONE[bre_pkg::T_W:1];
                    n_step    = '0;
                    n_start   = 1'b1;
                    n_state   = S_BIS;
                end else if (r_j == w_last) begin
                    n_res_y    = r_last_y;
                    n_res_conv = 1'b1;
                    n_res_seg  = '0;
                    n_state    = S_PUSH;
                end else begin
                    n_prev = w_rdata;
                    n_j    = r_j + bre_pkg::IDX_W'(1);
                end
            end
            S_BIS: begin
                if (w_xs.done) begin
                    if ({{(bre_pkg::COORD_W - bre_pkg::TOL_W){1'b0}}, r_tol} > w_err) begin
                        n_res_y    = w_ym;
                        n_res_conv = 1'b1;
                        n_state    = S_PUSH;
                    end else begin
                        if (w_xm < r_q) begin
                            n_lo = {1'b0, r_t};
                        end else begin
                            n_hi = {1'b0, r_t};
                        end
                        w_sum   = {1'b0, n_lo} + {1'b0, n_hi};
                        n_t     = w_sum[bre_pkg::T_W:1];
                        n_step  = r_step + bre_pkg::STEP_W'(1);
                        n_start = 1'b1;
                        if (r_step == bre_pkg::STEP_W'(bre_pkg::BISECT_STEPS - 1)) begin
                            n_state = S_FINAL;
                        end
                    end
                end
            end
            S_FINAL: begin
                if (w_ys.done) begin
                    n_res_y    = w_ym;
                    n_res_conv = 1'b0;
                    n_state    = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!r_ov || i_out_ready) begin
                    n_ov    = 1'b1;
                    n_oy    = r_res_y;
                    n_oc    = r_res_conv;
                    n_os    = r_res_seg;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
            r_ov    <= n_ov;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= '0;
            r_tol <= bre_pkg::TOL_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bre_pkg::CFG_POINT_COUNT: r_pc  <= i_cfg_data[bre_pkg::CNT_W-1:0];
                bre_pkg::CFG_MATCH_TOL:   r_tol <= i_cfg_data;
                default:                  r_tol <= r_tol;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_q        <= n_q;
        r_prev     <= n_prev;
        r_cur      <= n_cur;
        r_j        <= n_j;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_t        <= n_t;
        r_step     <= n_step;
        r_last_y   <= n_last_y;
        r_res_y    <= n_res_y;
        r_res_conv <= n_res_conv;
        r_res_seg  <= n_res_seg;
        r_oy       <= n_oy;
        r_oc       <= n_oc;
        r_os       <= n_os;
    end

    assign o_out_valid    = r_ov;
    assign o_curve_y      = r_oy;
    assign o_converged    = r_oc;
    assign o_segment_used = r_os;

endmodule

### hdl/bre_checker.sv
// port-level checks for the bezier curve evaluator, bound to the top level
`include "bezier_response_curve_eval_defines.svh"

module bre_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input logic            i_action,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input bre_pkg::t_coord o_curve_y
);

    // a stalled result holds
    `BRE_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_curve_y), "stalled result changed")

    // an evaluate transfer keeps the input side closed the next cycle
    `BRE_ASSERT_NEXT(a_eval_busy, i_in_valid && o_in_ready && (i_action == bre_pkg::ACT_EVAL), !o_in_ready, "input open right after an evaluate transfer")

    // no result appears in the cycle right after an input transfer
    `BRE_ASSERT_NOW(a_no_fast_result, $rose(o_out_valid), !$past(i_in_valid && o_in_ready), "result too soon after a transfer")

endmodule

bind bezier_response_curve_eval bre_checker u_bre_checker (.*);
